// ===== src/srrw_pkg.sv =====
// Package for the selective-repeat receive window: widths, window size,
// result kind codes and the result record passed to the output stage.
// No dependencies.
package srrw_pkg;

   localparam int WINDOW     = 16;              // power of two, slot = seq mod WINDOW
   localparam int SLOT_W     = $clog2(WINDOW);
   localparam int SEQ_W      = 32;
   localparam int PAY_W      = 64;
   localparam int REQ_DATA_W = 96;              // seq + payload
   localparam int RSP_DATA_W = 104;             // seq + payload + done, padded to bytes
   localparam int RSP_PAD_W  = RSP_DATA_W - SEQ_W - PAY_W - 1;

   localparam logic [SEQ_W-1:0] SEQ_TOP = '1;

   typedef enum logic {
      KIND_ACK     = 1'b0,
      KIND_DELIVER = 1'b1
   } result_kind_type;

   typedef struct packed {
      result_kind_type  kind;
      logic [SEQ_W-1:0] seq;
      logic [PAY_W-1:0] payload;
      logic             last;
      logic             done;
   } result_type;

endpackage

// ===== src/srrw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srrw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/srrw_out_reg.sv =====
// Output register for result transfers: holds one result until taken.
// Depends on srrw_pkg.
module srrw_out_reg
   import srrw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  result_type            load_data,
   output logic                  free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   always_comb begin
      free     = !valid_ff || rsp_tready;
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), data_ff.done, data_ff.payload, data_ff.seq};
   assign rsp_tuser  = data_ff.kind;
   assign rsp_tlast  = data_ff.last;

endmodule

// ===== src/srrw_ctrl.sv =====
// Window controller: classifies arriving packets, keeps the window base, slot
// valid bits and done flag, and sequences in-order delivery out of the payload RAM.
// Depends on srrw_pkg.
module srrw_ctrl
   import srrw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [SEQ_W-1:0]      csr_wr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  out_free,
   output logic                  out_load,
   output result_type            out_data,
   output logic                  ram_wr_en,
   output logic [SLOT_W-1:0]     ram_wr_addr,
   output logic [PAY_W-1:0]      ram_wr_data,
   output logic                  ram_rd_en,
   output logic [SLOT_W-1:0]     ram_rd_addr,
   input  logic [PAY_W-1:0]      ram_rd_data
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [SEQ_W-1:0]   base_ff, base_in;
   logic [WINDOW-1:0]  valid_ff, valid_in;
   logic               done_ff, done_in;
   logic [SEQ_W-1:0]   count_ff, count_in;

   logic [SEQ_W-1:0]   req_seq;
   logic [PAY_W-1:0]   req_pay;
   logic [SEQ_W-1:0]   diff;
   logic [SEQ_W-1:0]   low;
   logic [SEQ_W-1:0]   base_next;
   logic               accept;
   logic               halted;
   logic               in_win;
   logic               behind;
   logic               del_last;
   logic               del_done;

   always_comb begin
      req_seq    = req_tdata[SEQ_W-1:0];
      req_pay    = req_tdata[SEQ_W +: PAY_W];
      req_tready = (state_ff == S_IDLE) && out_free;
      accept     = req_tvalid && req_tready;
      halted     = done_ff || (base_ff >= count_ff);
      diff       = req_seq - base_ff;
      in_win     = (req_seq >= base_ff) && (diff < SEQ_W'(WINDOW));
      // lower bound of the old range clamps at zero
      low        = (base_ff >= SEQ_W'(WINDOW)) ? base_ff - SEQ_W'(WINDOW) : '0;
      behind     = (req_seq < base_ff) && (req_seq >= low);
      base_next  = base_ff + SEQ_W'(1);

      state_in = state_ff;
      base_in  = base_ff;
      valid_in = valid_ff;
      done_in  = done_ff;
      count_in = csr_wr_en ? csr_wr_data : count_ff;

      out_load = 1'b0;
      out_data = '{kind: KIND_ACK, seq: req_seq, payload: '0, last: 1'b1, done: 1'b0};

      ram_wr_en   = 1'b0;
      ram_wr_addr = req_seq[SLOT_W-1:0];
      ram_wr_data = req_pay;
      ram_rd_en   = 1'b0;
      ram_rd_addr = base_ff[SLOT_W-1:0];

      del_last = 1'b1;
      del_done = base_next >= count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (halted) begin
                  done_in = 1'b1;
               end else if (in_win) begin
                  if (!valid_ff[req_seq[SLOT_W-1:0]]) begin
                     ram_wr_en = 1'b1;
                     valid_in[req_seq[SLOT_W-1:0]] = 1'b1;
                  end
                  out_load      = 1'b1;
                  // packet at base always starts a delivery run
                  out_data.last = (req_seq != base_ff);
                  if (req_seq == base_ff) begin
                     state_in = S_READ;
                  end
               end else if (behind) begin
                  out_load = 1'b1;
               end
            end
         end
         S_READ: begin
            ram_rd_en = 1'b1;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               valid_in[base_ff[SLOT_W-1:0]] = 1'b0;
               base_in  = base_next;
               del_last = (base_next == SEQ_TOP) || !valid_in[base_next[SLOT_W-1:0]];
               out_load = 1'b1;
               out_data = '{kind: KIND_DELIVER, seq: base_ff, payload: ram_rd_data,
                            last: del_last, done: del_done};
               if (del_last) begin
                  done_in  = done_ff || del_done;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         base_ff  <= '0;
         valid_ff <= '0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         base_ff  <= base_in;
         valid_ff <= valid_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== src/selective_repeat_receive_window_core.sv =====
// Selective-repeat receive window, top level.
// An acknowledgement is registered, so it is on rsp in the cycle after the req
// transfer. Each in-order delivery is a payload RAM read, then an output load that
// waits while the output register is full; req is not taken until the run is out.
// Reset clears window base, slot valid bits, done flag and packet count at once;
// payload RAM is not cleared and no clearing pass is needed.
module selective_repeat_receive_window_core
   import srrw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [SEQ_W-1:0]      csr_wr_data,   // packet_count
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,     // seq_number, payload_word
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,     // result_seq, delivered_payload,
                                                // transfer_done, zero pad
   output logic                  rsp_tuser,     // result_kind
   output logic                  rsp_tlast      // last_of_run
);

   logic              out_free;
   logic              out_load;
   result_type        out_data;
   logic              ram_wr_en;
   logic [SLOT_W-1:0] ram_wr_addr;
   logic [PAY_W-1:0]  ram_wr_data;
   logic              ram_rd_en;
   logic [SLOT_W-1:0] ram_rd_addr;
   logic [PAY_W-1:0]  ram_rd_data;

   srrw_ram #(
      .WIDTH (PAY_W),
      .DEPTH (WINDOW)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   srrw_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .out_free    (out_free),
      .out_load    (out_load),
      .out_data    (out_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   srrw_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .load_data  (out_data),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== verif/srrw_result_checker.sv =====
// Result checker for the selective-repeat receive window: watches the csr, req and
// rsp channels, predicts every result of each accepted packet and compares in order.
// Depends on srrw_pkg for widths, window size, result kind codes and the result record.
module srrw_result_checker
   import srrw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [SEQ_W-1:0]      csr_wr_data,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,     // seq_number, payload_word
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,     // result_seq, delivered_payload,
                                                // transfer_done, zero pad
   input  logic                  rsp_tuser,     // result_kind
   input  logic                  rsp_tlast,     // last_of_run
   output int                    fail_count,
   output int                    pending_count,
   output int                    accepted_count,
   output int                    result_count,
   output logic [SEQ_W-1:0]      base_now,
   output logic                  done_now
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PRINTED = 200;

   logic [SEQ_W-1:0] packet_count;
   logic [SEQ_W-1:0] window_base;
   logic             slot_valid [WINDOW];
   logic [PAY_W-1:0] slot_payload [WINDOW];
   logic             done_flag;
   result_type       expected_results [$];
   int               fails = 0;
   int               accepted = 0;
   int               results_seen = 0;

   task automatic report_mismatch(input string what, input logic [PAY_W-1:0] got,
                                  input logic [PAY_W-1:0] want);
      fails++;
      if (fails <= MAX_PRINTED)
         $display("MISMATCH at result %0d, %s: got %0h, expected %0h",
                  results_seen, what, got, want);
   endtask

   // Window update for one arriving packet; queues its ack and any in-order deliveries.
   task automatic predict_packet(input logic [SEQ_W-1:0] seq, input logic [PAY_W-1:0] pay);
      logic [SEQ_W-1:0] offset;
      logic [SEQ_W-1:0] low_edge;
      logic [SEQ_W-1:0] del_seq [WINDOW];
      logic [PAY_W-1:0] del_pay [WINDOW];
      logic             del_done [WINDOW];
      int               n_del;
      result_type       entry;
      n_del = 0;
      if (done_flag || window_base >= packet_count) begin
         done_flag = 1'b1;
         return;
      end
      offset = seq - window_base;
      if (seq >= window_base && offset < WINDOW) begin
         if (!slot_valid[seq[SLOT_W-1:0]]) begin
            slot_payload[seq[SLOT_W-1:0]] = pay;
            slot_valid[seq[SLOT_W-1:0]]   = 1'b1;
         end
         if (seq == window_base) begin
            while (n_del < WINDOW && window_base != SEQ_TOP &&
                   slot_valid[window_base[SLOT_W-1:0]]) begin
               slot_valid[window_base[SLOT_W-1:0]] = 1'b0;
               del_seq[n_del] = window_base;
               del_pay[n_del] = slot_payload[window_base[SLOT_W-1:0]];
               window_base    = window_base + SEQ_W'(1);
               del_done[n_del] = (window_base >= packet_count);
               n_del++;
            end
            if (window_base >= packet_count)
               done_flag = 1'b1;
         end
         entry.kind    = KIND_ACK;
         entry.seq     = seq;
         entry.payload = '0;
         entry.last    = (n_del == 0);
         entry.done    = 1'b0;
         expected_results.push_back(entry);
         for (int i = 0; i < n_del; i++) begin
            entry.kind    = KIND_DELIVER;
            entry.seq     = del_seq[i];
            entry.payload = del_pay[i];
            entry.last    = (i == n_del - 1);
            entry.done    = del_done[i];
            expected_results.push_back(entry);
         end
         return;
      end
      // just behind the window: lower edge clamps at zero
      low_edge = (window_base >= WINDOW) ? window_base - WINDOW : '0;
      if (seq < window_base && seq >= low_edge) begin
         entry.kind    = KIND_ACK;
         entry.seq     = seq;
         entry.payload = '0;
         entry.last    = 1'b1;
         entry.done    = 1'b0;
         expected_results.push_back(entry);
      end
   endtask

   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         packet_count = '0;
         window_base  = '0;
         done_flag    = 1'b0;
         for (int i = 0; i < WINDOW; i++) begin
            slot_valid[i]   = 1'b0;
            slot_payload[i] = '0;
         end
         expected_results.delete();
      end else begin
         if (csr_wr_en)
            packet_count = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected, seq",
                               PAY_W'(rsp_tdata[SEQ_W-1:0]), '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tuser !== want.kind)
                  report_mismatch("result_kind", PAY_W'(rsp_tuser), PAY_W'(want.kind));
               if (rsp_tdata[SEQ_W-1:0] !== want.seq)
                  report_mismatch("result_seq", PAY_W'(rsp_tdata[SEQ_W-1:0]),
                                  PAY_W'(want.seq));
               if (rsp_tdata[SEQ_W +: PAY_W] !== want.payload)
                  report_mismatch("delivered_payload", rsp_tdata[SEQ_W +: PAY_W], want.payload);
               if (rsp_tlast !== want.last)
                  report_mismatch("last_of_run", PAY_W'(rsp_tlast), PAY_W'(want.last));
               if (rsp_tdata[SEQ_W+PAY_W] !== want.done)
                  report_mismatch("transfer_done", PAY_W'(rsp_tdata[SEQ_W+PAY_W]),
                                  PAY_W'(want.done));
               if (rsp_tdata[RSP_DATA_W-1:SEQ_W+PAY_W+1] !== '0)
                  report_mismatch("tdata pad",
                                  PAY_W'(rsp_tdata[RSP_DATA_W-1:SEQ_W+PAY_W+1]), '0);
            end
            results_seen++;
         end
         if (req_tvalid && req_tready) begin
            predict_packet(req_tdata[SEQ_W-1:0], req_tdata[SEQ_W +: PAY_W]);
            accepted++;
         end
      end
      fail_count     <= fails;
      pending_count  <= expected_results.size();
      accepted_count <= accepted;
      result_count   <= results_seen;
      base_now       <= window_base;
      done_now       <= done_flag;
   end

endmodule

// ===== verif/tb_selective_repeat_receive_window_core.sv =====
// Testbench top for selective_repeat_receive_window_core: clock, reset, packet
// stimulus, packet_count writes, rsp back-pressure and the final verdict.
// Depends on srrw_pkg, the core and srrw_result_checker.
module tb_selective_repeat_receive_window_core;
   import srrw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 48;      // longest busy stretch is a full-window delivery run
   localparam int HOLD_AT      = 150;
   localparam int HOLD_CYCLES  = 400;
   localparam int CALM_FROM    = 180;
   localparam int CALM_TO      = 230;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [SEQ_W-1:0]      csr_wr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;       // seq_number, payload_word
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;            // result_seq, delivered_payload,
                                                // transfer_done, zero pad
   logic                  rsp_tuser;            // result_kind
   logic                  rsp_tlast;            // last_of_run

   int                    fail_count;
   int                    pending_count;
   int                    accepted_count;
   int                    result_count;
   logic [SEQ_W-1:0]      base_now;
   logic                  done_now;
   logic                  calm;
   int                    hold_left = 0;
   bit                    hold_done = 1'b0;

   selective_repeat_receive_window_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   srrw_result_checker results_check (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .rsp_tlast      (rsp_tlast),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .accepted_count (accepted_count),
      .result_count   (result_count),
      .base_now       (base_now),
      .done_now       (done_now)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // no idling on either side while this holds
   assign calm = (accepted_count >= CALM_FROM) && (accepted_count < CALM_TO);

   // receiver: random stalls, plus one long hold-off that backs the window up into req
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!hold_done && accepted_count >= HOLD_AT) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(0, 99) >= 31);
      end
   end

   task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic [PAY_W-1:0] pay);
      while (!calm && $urandom_range(0, 99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pay, seq};
      do @(posedge clock); while (!req_tready);
   endtask

   // drop valid, let every expected result out, then give the core time to go idle
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [SEQ_W-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [PAY_W-1:0] random_payload();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '1;
      if (r < 10) return '0;
      return {$urandom, $urandom};
   endfunction

   // mostly in or just behind the window, some just outside, some anywhere
   function automatic logic [SEQ_W-1:0] pick_seq(input logic [SEQ_W-1:0] b);
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return b;
      if (r < 65) return b + $urandom_range(1, WINDOW - 1);
      if (r < 82) return b - $urandom_range(1, WINDOW);
      if (r < 88) return b + WINDOW;
      if (r < 92) return b - WINDOW - 1;
      return $urandom;
   endfunction

   task automatic random_traffic(input int items, input bit stop_on_done);
      logic [SEQ_W-1:0] order [WINDOW];
      logic [SEQ_W-1:0] b;
      logic [SEQ_W-1:0] tmp;
      int               i;
      int               j;
      int               k;
      int               m;
      i = 0;
      while (i < items && !(stop_on_done && done_now)) begin
         if ($urandom_range(0, 9) == 0) begin
            // fill the window above base out of order, then release it with base
            req_tvalid <= 1'b0;
            @(posedge clock);
            b = base_now;
            k = $urandom_range(1, WINDOW - 1);
            for (j = 0; j < k; j++) order[j] = b + j + 1;
            for (j = k - 1; j > 0; j--) begin
               m = $urandom_range(0, j);
               tmp = order[j];
               order[j] = order[m];
               order[m] = tmp;
            end
            for (j = 0; j < k; j++) send_packet(order[j], random_payload());
            send_packet(b, random_payload());
            i += k + 1;
         end else begin
            send_packet(pick_seq(base_now), random_payload());
            i++;
         end
      end
   endtask

   initial begin : stimulus
      int s;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      write_count(SEQ_TOP);
      send_packet(0, '1);                      // base packet: ack plus one delivery
      send_packet(0, '0);                      // behind, lower edge clamped at zero
      send_packet(SEQ_TOP, '0);                // far ahead, ignored
      send_packet(16, 64'hAAAA_AAAA_AAAA_AAAA); // top slot of the window
      send_packet(17, random_payload());       // one past the top, ignored
      send_packet(16, 64'h5555_5555_5555_5555); // duplicate, stored payload kept
      for (s = 15; s >= 2; s--) send_packet(s, random_payload());
      send_packet(1, random_payload());        // releases a full window
      send_packet(0, random_payload());        // below the lower edge, ignored
      send_packet(1, random_payload());        // oldest re-acked number
      send_packet(32'h8000_0000, random_payload());
      send_packet(32, random_payload());

      write_count(32'h8000_0000);
      random_traffic(100, 1'b0);

      write_count(32'h0001_0000);
      random_traffic(110, 1'b0);

      // count just ahead of base, so the transfer completes
      settle();
      write_count(base_now + 40);
      random_traffic(150, 1'b1);
      repeat (4) send_packet(pick_seq(base_now), random_payload());
      write_count('0);
      repeat (4) send_packet(pick_seq(base_now), random_payload());

      settle();
      $display("Run covered %0d packets in and %0d results out; window base ended at %0d.",
               accepted_count, result_count, base_now);
      $display("packet_count went through max, mid, small, just-ahead and zero settings.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("selective_repeat_receive_window_core verification clean");
      end else begin
         $display("selective_repeat_receive_window_core verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #4_000_000;
      $display("selective_repeat_receive_window_core verification failed");
      $finish;
   end

endmodule

// ===== selective_repeat_receive_window_core.f =====
src/srrw_pkg.sv
src/srrw_ram.sv
src/srrw_out_reg.sv
src/srrw_ctrl.sv
src/selective_repeat_receive_window_core.sv
verif/srrw_result_checker.sv
verif/tb_selective_repeat_receive_window_core.sv
